@@ rtl/bpfa_pkg.sv @@
`default_nettype none

package bpfa_pkg;

   localparam int unsigned BITMAP_WORDS = 1024;
   localparam int unsigned PAGE_SHIFT   = 12;
   localparam int unsigned PAGE_BYTES   = 1 << PAGE_SHIFT;
   localparam int unsigned WORD_BITS    = 32;
   localparam int unsigned BIT_IDX_W    = $clog2(WORD_BITS);
   localparam int unsigned WORD_IDX_W   = $clog2(BITMAP_WORDS);
   localparam int unsigned PAGE_IDX_W   = WORD_IDX_W + BIT_IDX_W;
   localparam int unsigned PAGE_CAP     = BITMAP_WORDS * WORD_BITS;
   localparam int unsigned HINT_W       = 16;
   localparam int unsigned COUNT_W      = 28;
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned PCOUNT_W     = 16;
   localparam int unsigned FUNC_W       = 2;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CSR_IDX_W    = 1;

   typedef logic [WORD_BITS-1:0]         word_type;
   typedef logic [WORD_IDX_W-1:0]        widx_type;
   typedef logic [PAGE_IDX_W-1:0]        pidx_type;
   typedef logic [BIT_IDX_W-1:0]         bidx_type;
   typedef logic [BIT_IDX_W:0]           bcnt_type;
   typedef logic [HINT_W-1:0]            hint_type;
   typedef logic [COUNT_W-1:0]           count_type;
   typedef logic [ADDR_W-1:0]            addr_type;
   typedef logic [ADDR_W:0]              wide_type;
   typedef logic [ADDR_W-PAGE_SHIFT-1:0] apage_type;
   typedef logic [ADDR_W-PAGE_SHIFT:0]   rpage_type;
   typedef logic [PCOUNT_W-1:0]          pcount_type;

   localparam hint_type  HINT_NONE = '1;
   localparam count_type COUNT_MAX = '1;
   localparam word_type  WORD_ONES = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_REGION = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_PAGE = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDRESS = 1'd0,
      CSR_PAGE_COUNT   = 1'd1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ALLOC_WR,
      ST_SCAN,
      ST_FREE_WR,
      ST_REG_A,
      ST_REG_B,
      ST_CLR,
      ST_CLR_WR,
      ST_REG_FIN,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

@@ rtl/bpfa_if.sv @@
`default_nettype none

interface bpfa_req_if;
   logic                                valid;
   logic                                ready;
   logic [bpfa_pkg::FUNC_W-1:0]         func;
   logic [bpfa_pkg::ADDR_W-1:0]         addr;
   logic [bpfa_pkg::ADDR_W-1:0]         region_size;

   modport source (output valid, output func, output addr, output region_size, input ready);
   modport sink   (input valid, input func, input addr, input region_size, output ready);
endinterface

interface bpfa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bpfa_pkg::ADDR_W-1:0]         page_address;
   logic [bpfa_pkg::STATUS_W-1:0]       status;
   logic [bpfa_pkg::COUNT_W-1:0]        free_bytes;

   modport source (output valid, output page_address, output status, output free_bytes,
                   input ready);
   modport sink   (input valid, input page_address, input status, input free_bytes,
                   output ready);
endinterface

interface bpfa_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bpfa_pkg::CSR_IDX_W-1:0]      index;
   logic [bpfa_pkg::ADDR_W-1:0]         data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/bpfa_ram.sv @@
`default_nettype none

module bpfa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bitmap_page_frame_allocator_core.sv @@
// channel   dir  handshake     payload
// csr_bus   in   valid/ready   index, data (0 base_address, 1 page_count)
// req_bus   in   valid/ready   func, addr, region_size
// rsp_bus   out  valid/ready   page_address, status, free_bytes
//
// free clears and alloc sets its page bit by read-modify-write; alloc may then
// scan bitmap words for the next free page. region writes whole words clear and
// read-modify-writes partial edge words (single bitmap RAM port pair). func 3
// only responds. after reset all BITMAP_WORDS (1024) RAM words are set to ones
// before the first transaction is accepted; csr writes are taken anytime. a
// finished result sits in the rsp register while the next transaction runs;
// the block only stalls when a second result is ready and rsp is still held.
`default_nettype none

module bitmap_page_frame_allocator_core (
   input  logic              clock,
   input  logic              reset,
   bpfa_csr_if.sink          csr_bus,
   bpfa_req_if.sink          req_bus,
   bpfa_rsp_if.source        rsp_bus
);

   function automatic bpfa_pkg::count_type count_add(bpfa_pkg::count_type c,
                                                     bpfa_pkg::count_type b);
      logic [bpfa_pkg::COUNT_W:0] s;
      s = {1'b0, c} + {1'b0, b};
      return s[bpfa_pkg::COUNT_W] ? bpfa_pkg::COUNT_MAX : s[bpfa_pkg::COUNT_W-1:0];
   endfunction

   function automatic bpfa_pkg::count_type count_sub(bpfa_pkg::count_type c,
                                                     bpfa_pkg::count_type b);
      return (c > b) ? (c - b) : '0;
   endfunction

   function automatic bpfa_pkg::bidx_type first_zero(bpfa_pkg::word_type d);
      bpfa_pkg::bidx_type k;
      k = '0;
      for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (!d[i]) begin
            k = bpfa_pkg::bidx_type'(i);
         end
      end
      return k;
   endfunction

   // control and config registers
   bpfa_pkg::state_type   state_ff, state_in;
   bpfa_pkg::widx_type    init_cnt_ff, init_cnt_in;
   bpfa_pkg::addr_type    base_ff, base_in;
   bpfa_pkg::pcount_type  pcount_ff, pcount_in;
   bpfa_pkg::hint_type    hint_ff, hint_in;
   bpfa_pkg::count_type   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // working registers
   bpfa_pkg::pidx_type    pg_ff, pg_in;
   bpfa_pkg::addr_type    addr_ff, addr_in;
   bpfa_pkg::addr_type    size_ff, size_in;
   bpfa_pkg::wide_type    end_ff, end_in;
   bpfa_pkg::addr_type    soff_ff, soff_in;
   bpfa_pkg::hint_type    fst_ff, fst_in;
   bpfa_pkg::hint_type    last_ff, last_in;
   bpfa_pkg::widx_type    cur_w_ff, cur_w_in;
   bpfa_pkg::word_type    mask_ff, mask_in;
   bpfa_pkg::hint_type    scan_p_ff, scan_p_in;
   logic                  fwd_ff, fwd_in;
   bpfa_pkg::word_type    fwd_data_ff, fwd_data_in;
   bpfa_pkg::addr_type    page_addr_ff, page_addr_in;
   bpfa_pkg::status_type  status_ff, status_in;
   bpfa_pkg::addr_type    rsp_page_ff, rsp_page_in;
   bpfa_pkg::status_type  rsp_status_ff, rsp_status_in;
   bpfa_pkg::count_type   rsp_free_ff, rsp_free_in;

   // bitmap memory
   logic                  mem_we;
   bpfa_pkg::widx_type    mem_waddr;
   bpfa_pkg::word_type    mem_wdata;
   logic                  mem_re;
   bpfa_pkg::widx_type    mem_raddr;
   bpfa_pkg::word_type    mem_rdata;

   bpfa_ram #(
      .WIDTH (bpfa_pkg::WORD_BITS),
      .DEPTH (bpfa_pkg::BITMAP_WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // handshakes
   logic req_acc, csr_acc, rsp_slot;
   assign req_bus.ready = (state_ff == bpfa_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign csr_acc  = csr_bus.valid;
   assign rsp_slot = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.page_address = rsp_page_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.free_bytes   = rsp_free_ff;

   // usable page limit
   bpfa_pkg::hint_type limit;
   assign limit = (32'(pcount_ff) < bpfa_pkg::PAGE_CAP) ? bpfa_pkg::hint_type'(pcount_ff)
                                                        : bpfa_pkg::hint_type'(bpfa_pkg::PAGE_CAP);

   // alloc entry
   logic alloc_none;
   assign alloc_none = (hint_ff >= limit);

   // free entry
   bpfa_pkg::addr_type  f_off;
   bpfa_pkg::apage_type f_pg;
   logic                f_oor;
   assign f_off = req_bus.addr - base_ff;
   assign f_pg  = f_off[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
   assign f_oor = (req_bus.addr < base_ff) || (f_pg >= bpfa_pkg::apage_type'(limit));

   // alloc write-back
   bpfa_pkg::word_type alloc_word;
   bpfa_pkg::word_type free_word;
   bpfa_pkg::hint_type alloc_p;
   assign alloc_word = mem_rdata | (bpfa_pkg::word_type'(1) << pg_ff[bpfa_pkg::BIT_IDX_W-1:0]);
   assign free_word  = mem_rdata & ~(bpfa_pkg::word_type'(1) << pg_ff[bpfa_pkg::BIT_IDX_W-1:0]);
   assign alloc_p    = bpfa_pkg::hint_type'(pg_ff) + 1'b1;

   // scan, one word per cycle
   bpfa_pkg::widx_type scan_w;
   bpfa_pkg::word_type scan_raw, scan_dat;
   logic               scan_hit;
   bpfa_pkg::bidx_type scan_k;
   bpfa_pkg::hint_type scan_next;
   assign scan_w    = scan_p_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
   assign scan_raw  = fwd_ff ? fwd_data_ff : mem_rdata;
   assign scan_dat  = scan_raw | ~(bpfa_pkg::WORD_ONES << scan_p_ff[bpfa_pkg::BIT_IDX_W-1:0]);
   assign scan_hit  = (scan_dat != bpfa_pkg::WORD_ONES);
   assign scan_k    = first_zero(scan_dat);
   assign scan_next = bpfa_pkg::hint_type'({scan_w, bpfa_pkg::bidx_type'(0)})
                      + bpfa_pkg::hint_type'(bpfa_pkg::WORD_BITS);

   // region bounds
   bpfa_pkg::wide_type  reg_span, fst_sum;
   logic                reg_pos, reg_nonempty;
   bpfa_pkg::rpage_type fst_full, last_raw, last_cl;
   assign reg_pos  = end_ff > {1'b0, base_ff};
   assign reg_span = end_ff - {1'b0, base_ff};
   assign fst_sum  = {1'b0, soff_ff} + bpfa_pkg::wide_type'(bpfa_pkg::PAGE_BYTES - 1);
   assign fst_full = fst_sum[bpfa_pkg::ADDR_W:bpfa_pkg::PAGE_SHIFT];
   assign last_raw = reg_span[bpfa_pkg::ADDR_W:bpfa_pkg::PAGE_SHIFT];
   assign last_cl  = (last_raw > bpfa_pkg::rpage_type'(limit)) ? bpfa_pkg::rpage_type'(limit)
                                                             : last_raw;
   assign reg_nonempty = reg_pos && (last_cl > fst_full);

   // region clear, one word at a time
   bpfa_pkg::hint_type last_m1, clr_rel;
   logic               clr_last, clr_full;
   bpfa_pkg::bidx_type clr_lo;
   bpfa_pkg::bcnt_type clr_hi;
   bpfa_pkg::word_type clr_mask;
   assign last_m1  = last_ff - 1'b1;
   assign clr_last = (cur_w_ff == last_m1[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W]);
   assign clr_lo   = (cur_w_ff == fst_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W])
                     ? fst_ff[bpfa_pkg::BIT_IDX_W-1:0] : '0;
   assign clr_rel  = last_ff - bpfa_pkg::hint_type'({cur_w_ff, bpfa_pkg::bidx_type'(0)});
   assign clr_hi   = clr_last ? clr_rel[bpfa_pkg::BIT_IDX_W:0]
                              : bpfa_pkg::bcnt_type'(bpfa_pkg::WORD_BITS);
   assign clr_mask = (bpfa_pkg::WORD_ONES << clr_lo)
                     & (bpfa_pkg::WORD_ONES >> (bpfa_pkg::bcnt_type'(bpfa_pkg::WORD_BITS) - clr_hi));
   assign clr_full = (clr_mask == bpfa_pkg::WORD_ONES);

   bpfa_pkg::hint_type  reg_pages;
   assign reg_pages = last_ff - fst_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpfa_pkg::ST_INIT: begin
            if (init_cnt_ff == bpfa_pkg::widx_type'(bpfa_pkg::BITMAP_WORDS - 1)) begin
               state_in = bpfa_pkg::ST_IDLE;
            end
         end
         bpfa_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_bus.func)
                  bpfa_pkg::FUNC_ALLOC:
                     state_in = alloc_none ? bpfa_pkg::ST_RESP : bpfa_pkg::ST_ALLOC_WR;
                  bpfa_pkg::FUNC_FREE:
                     state_in = f_oor ? bpfa_pkg::ST_RESP : bpfa_pkg::ST_FREE_WR;
                  bpfa_pkg::FUNC_REGION:
                     state_in = bpfa_pkg::ST_REG_A;
                  default:
                     state_in = bpfa_pkg::ST_RESP;
               endcase
            end
         end
         bpfa_pkg::ST_ALLOC_WR: begin
            state_in = (alloc_p >= limit) ? bpfa_pkg::ST_RESP : bpfa_pkg::ST_SCAN;
         end
         bpfa_pkg::ST_SCAN: begin
            if (scan_hit || (scan_next >= limit)) begin
               state_in = bpfa_pkg::ST_RESP;
            end
         end
         bpfa_pkg::ST_FREE_WR: state_in = bpfa_pkg::ST_RESP;
         bpfa_pkg::ST_REG_A:   state_in = bpfa_pkg::ST_REG_B;
         bpfa_pkg::ST_REG_B: begin
            state_in = reg_nonempty ? bpfa_pkg::ST_CLR : bpfa_pkg::ST_RESP;
         end
         bpfa_pkg::ST_CLR: begin
            if (!clr_full) begin
               state_in = bpfa_pkg::ST_CLR_WR;
            end else if (clr_last) begin
               state_in = bpfa_pkg::ST_REG_FIN;
            end
         end
         bpfa_pkg::ST_CLR_WR: begin
            state_in = clr_last ? bpfa_pkg::ST_REG_FIN : bpfa_pkg::ST_CLR;
         end
         bpfa_pkg::ST_REG_FIN: state_in = bpfa_pkg::ST_RESP;
         bpfa_pkg::ST_RESP: begin
            if (rsp_slot) begin
               state_in = bpfa_pkg::ST_IDLE;
            end
         end
         default: state_in = bpfa_pkg::ST_INIT;
      endcase
   end

   // datapath and memory control
   always_comb begin
      init_cnt_in   = init_cnt_ff;
      base_in       = base_ff;
      pcount_in     = pcount_ff;
      hint_in       = hint_ff;
      count_in      = count_ff;
      pg_in         = pg_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      end_in        = end_ff;
      soff_in       = soff_ff;
      fst_in        = fst_ff;
      last_in       = last_ff;
      cur_w_in      = cur_w_ff;
      mask_in       = mask_ff;
      scan_p_in     = scan_p_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      page_addr_in  = page_addr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_w_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = cur_w_ff;

      if (csr_acc) begin
         case (csr_bus.index)
            bpfa_pkg::CSR_BASE_ADDRESS: base_in = csr_bus.data;
            bpfa_pkg::CSR_PAGE_COUNT:   pcount_in = csr_bus.data[bpfa_pkg::PCOUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         bpfa_pkg::ST_INIT: begin
            mem_we      = 1'b1;
            mem_waddr   = init_cnt_ff;
            mem_wdata   = bpfa_pkg::WORD_ONES;
            init_cnt_in = init_cnt_ff + 1'b1;
         end
         bpfa_pkg::ST_IDLE: begin
            if (req_acc) begin
               addr_in      = req_bus.addr;
               size_in      = req_bus.region_size;
               page_addr_in = '0;
               status_in    = bpfa_pkg::STATUS_OK;
               case (req_bus.func)
                  bpfa_pkg::FUNC_ALLOC: begin
                     pg_in     = hint_ff[bpfa_pkg::PAGE_IDX_W-1:0];
                     mem_re    = 1'b1;
                     mem_raddr = hint_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
                     if (alloc_none) begin
                        status_in = bpfa_pkg::STATUS_NO_PAGE;
                     end
                  end
                  bpfa_pkg::FUNC_FREE: begin
                     pg_in     = f_pg[bpfa_pkg::PAGE_IDX_W-1:0];
                     mem_re    = 1'b1;
                     mem_raddr = f_pg[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
                     if (f_oor) begin
                        status_in = bpfa_pkg::STATUS_RANGE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bpfa_pkg::ST_ALLOC_WR: begin
            mem_we       = 1'b1;
            mem_waddr    = pg_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
            mem_wdata    = alloc_word;
            count_in     = count_sub(count_ff, bpfa_pkg::count_type'(bpfa_pkg::PAGE_BYTES));
            page_addr_in = base_ff + (bpfa_pkg::addr_type'(pg_ff) << bpfa_pkg::PAGE_SHIFT);
            // the first scan word may be the one written this cycle
            mem_re       = 1'b1;
            mem_raddr    = alloc_p[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
            fwd_in       = (alloc_p[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W]
                            == pg_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W]);
            fwd_data_in  = alloc_word;
            scan_p_in    = alloc_p;
            if (alloc_p >= limit) begin
               hint_in = bpfa_pkg::HINT_NONE;
            end
         end
         bpfa_pkg::ST_SCAN: begin
            fwd_in    = 1'b0;
            mem_re    = 1'b1;
            mem_raddr = scan_w + 1'b1;
            scan_p_in = scan_next;
            if (scan_hit) begin
               hint_in = bpfa_pkg::hint_type'({scan_w, scan_k});
            end else if (scan_next >= limit) begin
               hint_in = bpfa_pkg::HINT_NONE;
            end
         end
         bpfa_pkg::ST_FREE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pg_ff[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
            mem_wdata = free_word;
            count_in  = count_add(count_ff, bpfa_pkg::count_type'(bpfa_pkg::PAGE_BYTES));
            if (hint_ff > bpfa_pkg::hint_type'(pg_ff)) begin
               hint_in = bpfa_pkg::hint_type'(pg_ff);
            end
         end
         bpfa_pkg::ST_REG_A: begin
            end_in  = {1'b0, addr_ff} + {1'b0, size_ff};
            soff_in = (addr_ff < base_ff) ? '0 : (addr_ff - base_ff);
         end
         bpfa_pkg::ST_REG_B: begin
            fst_in   = bpfa_pkg::hint_type'(fst_full);
            last_in  = bpfa_pkg::hint_type'(last_cl);
            cur_w_in = fst_full[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_IDX_W];
         end
         bpfa_pkg::ST_CLR: begin
            mask_in = clr_mask;
            if (clr_full) begin
               // whole word freed, no read needed
               mem_we    = 1'b1;
               mem_waddr = cur_w_ff;
               mem_wdata = '0;
               cur_w_in  = cur_w_ff + 1'b1;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cur_w_ff;
            end
         end
         bpfa_pkg::ST_CLR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_w_ff;
            mem_wdata = mem_rdata & ~mask_ff;
            cur_w_in  = cur_w_ff + 1'b1;
         end
         bpfa_pkg::ST_REG_FIN: begin
            count_in = count_add(count_ff,
                                 bpfa_pkg::count_type'(reg_pages) << bpfa_pkg::PAGE_SHIFT);
            if (hint_ff > fst_ff) begin
               hint_in = fst_ff;
            end
         end
         bpfa_pkg::ST_RESP: begin
            if (rsp_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = page_addr_ff;
               rsp_status_in = status_ff;
               rsp_free_in   = count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpfa_pkg::ST_INIT;
         init_cnt_ff  <= '0;
         base_ff      <= '0;
         pcount_ff    <= '0;
         hint_ff      <= bpfa_pkg::HINT_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         base_ff      <= base_in;
         pcount_ff    <= pcount_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pg_ff         <= pg_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      end_ff        <= end_in;
      soff_ff       <= soff_in;
      fst_ff        <= fst_in;
      last_ff       <= last_in;
      cur_w_ff      <= cur_w_in;
      mask_ff       <= mask_in;
      scan_p_ff     <= scan_p_in;
      fwd_ff        <= fwd_in;
      fwd_data_ff   <= fwd_data_in;
      page_addr_ff  <= page_addr_in;
      status_ff     <= status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

endmodule

`default_nettype wire

@@ rtl/bpfa_checker.sv @@
`default_nettype none

module bpfa_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [bpfa_pkg::ADDR_W-1:0]       rsp_page_address,
   input  logic [bpfa_pkg::STATUS_W-1:0]     rsp_status,
   input  logic [bpfa_pkg::COUNT_W-1:0]      rsp_free_bytes
);

   // transactions accepted but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (pend_ff != 2'd0))
      else $error("response without a pending transaction");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd2) |-> !req_ready)
      else $error("accepted a third transaction");

   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bpfa_pkg::STATUS_OK)) |-> (rsp_page_address == '0))
      else $error("failed transaction returned a page address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_page_address)
                                     && $stable(rsp_status) && $stable(rsp_free_bytes)))
      else $error("stalled response changed");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_page_address (rsp_bus.page_address),
   .rsp_status       (rsp_bus.status),
   .rsp_free_bytes   (rsp_bus.free_bytes)
);

`default_nettype wire
